// File: design/jsp_pkg.sv
// Shared types and constants of the joystick-to-servo pulse conditioner.
// No dependencies; used by jsp_iter and the top level.
`default_nettype none
package jsp_pkg;

  // Curve table size; a power of two, entries are computed on demand
  localparam int unsigned CURVE_ENTRIES = 2048;
  localparam int unsigned LOG2_N        = $clog2(CURVE_ENTRIES);
  localparam int unsigned PULSE_MIN_US  = 500;
  localparam int unsigned PULSE_MAX_US  = 2500;
  localparam int unsigned PULSE_SPAN_US = PULSE_MAX_US - PULSE_MIN_US;
  localparam int unsigned PWM_PERIOD_US = 20000;
  localparam int unsigned ANGLE_FULL    = 180;
  localparam int unsigned ANGLE_SPAN    = 175;
  localparam int unsigned Q_ONE         = 16384;
  localparam int unsigned NORM_LIMIT    = 19661;
  localparam int unsigned REMOTE_MAX    = 160;

  // Reciprocals for the constant divides of the pulse width and duty count;
  // rounded up, exact for any 8-bit angle
  localparam int unsigned     US_SHIFT   = 16;
  localparam int unsigned     US_RECIP   =
    ((PULSE_SPAN_US << US_SHIFT) + ANGLE_FULL - 1) / ANGLE_FULL;
  localparam int unsigned     DUTY_SHIFT = 20;
  localparam longint unsigned DUTY_RECIP =
    ((64'd1 << (16 + DUTY_SHIFT)) + 64'(PWM_PERIOD_US) - 64'd1) / 64'(PWM_PERIOD_US);

  // Iteration counts of the shared unit
  localparam logic [4:0] T_STEPS    = 5'd30;
  localparam logic [4:0] SQ_STEPS   = 5'd15;

  // Opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_REMOTE = 2'd1;
  localparam logic [1:0] OP_PING   = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_EMA_W    = 3'd2;
  localparam logic [2:0] REG_DEADZONE = 3'd3;
  localparam logic [2:0] REG_TIMEOUT  = 3'd4;

  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [31:0] num;    // left aligned: bits are consumed from the top
    logic [15:0] den;
    logic [4:0]  steps;
  } iter_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } iter_rsp_t;

endpackage
`default_nettype wire

// File: design/jsp_iter.sv
// Shared iterative unit: restoring divide (one quotient bit a cycle) or
// digit-by-digit square root (one root bit a cycle). Depends on jsp_pkg.
`default_nettype none
module jsp_iter (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire jsp_pkg::iter_req_t req_i,
  output jsp_pkg::iter_rsp_t      rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        sq_q, sq_d;
  logic [31:0] num_q, num_d;
  logic [15:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [19:0] rem_q, rem_d;
  logic [31:0] res_q, res_d;

  logic [19:0] dshift, sshift, strial;
  logic        dge, sge;

  always_comb begin
    dshift = {rem_q[18:0], num_q[31]};
    dge    = dshift >= {4'b0, den_q};
    sshift = {rem_q[17:0], num_q[31:30]};
    strial = {res_q[17:0], 2'b01};
    sge    = sshift >= strial;

    busy_d = busy_q;
    done_d = 1'b0;
    sq_d   = sq_q;
    num_d  = num_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    res_d  = res_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      sq_d   = req_i.is_sqrt;
      num_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = req_i.steps;
      rem_d  = '0;
      res_d  = '0;
    end else if (busy_q) begin
      if (sq_q) begin
        num_d = {num_q[29:0], 2'b00};
        rem_d = sge ? sshift - strial : sshift;
        res_d = {res_q[30:0], sge};
      end else begin
        num_d = {num_q[30:0], 1'b0};
        rem_d = dge ? dshift - {4'b0, den_q} : dshift;
        res_d = {res_q[30:0], dge};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q  <= sq_d;
    num_q <= num_d;
    den_q <= den_d;
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule
`default_nettype wire

// File: design/joystick_to_servo_pulse_conditioner_top.sv
// Top level of the joystick-to-servo pulse conditioner: sequencer, state
// and output register. Depends on jsp_pkg and jsp_iter.
//
// Usage: the input channel (in_valid_i / in_stall_o) takes one beat per
// tick or remote frame; the output channel (out_valid_o / out_stall_i)
// gives one beat per joystick tick and none for remote frames.
// A remote frame is applied at the accepting edge and leaves in_stall_o low.
// A joystick tick raises in_stall_o until its result is loaded: per axis it
// runs the EMA and shaping, then a 30-step divide and two 15-step square roots for
// the curve entries on the one shared divide/sqrt unit, each run with a
// start and a done cycle; an axis inside the deadzone skips the divide and roots.
// Then come the mode step, each angle's pulse width and duty count through
// reciprocal multiplies, and the load; out_valid_o rises after the load.
// The result sits in an output register; the block takes the next beat
// while it waits, and a later tick holds in its last step until the
// receiver stops stalling and the register frees up.
// Reset clears the filters, mode, lamps and remote time, sets the remote
// angles to 90 and the registers to their defaults; no warm-up is needed.
// Configuration writes (cfg_we_i) take effect at once.
`default_nettype none
module joystick_to_servo_pulse_conditioner_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [11:0]        sample_x_i,
  input  wire logic [11:0]        sample_y_i,
  input  wire logic               red_button_i,
  input  wire logic               blue_button_i,
  input  wire logic [31:0]        now_ms_i,
  input  wire logic signed [15:0] yaw_tenths_i,
  input  wire logic signed [15:0] pitch_tenths_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [13:0]             pan_duty_o,
  output logic [13:0]             tilt_duty_o,
  output logic [7:0]              pan_angle_o,
  output logic [7:0]              tilt_angle_o,
  output logic                    remote_mode_o,
  output logic                    red_led_o,
  output logic                    blue_led_o
);

  localparam int unsigned L = jsp_pkg::LOG2_N;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EMA0 = 4'd1;
  localparam logic [3:0] S_EMA1 = 4'd2;
  localparam logic [3:0] S_SHP  = 4'd3;
  localparam logic [3:0] S_TDIV = 4'd4;
  localparam logic [3:0] S_SQ   = 4'd5;
  localparam logic [3:0] S_ENT  = 4'd6;
  localparam logic [3:0] S_INT  = 4'd7;
  localparam logic [3:0] S_ANG  = 4'd8;
  localparam logic [3:0] S_MODE = 4'd9;
  localparam logic [3:0] S_US   = 4'd10;
  localparam logic [3:0] S_DUTY = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  // Configuration
  logic [11:0] cx_q, cy_q;
  logic [8:0]  ew_q;
  logic [12:0] dz_q;
  logic [15:0] to_q;

  // Block state
  logic signed [16:0] smx_q, smx_d, smy_q, smy_d;
  logic        mode_q, mode_d, red_q, red_d, blue_q, blue_d;
  logic [31:0] last_q, last_d;
  logic [7:0]  rpan_q, rpan_d, rtilt_q, rtilt_d;

  // Sequencer
  logic [3:0]  state_q, state_d;
  logic        ax_q, ax_d, sent_q, sent_d, hi_q, hi_d;
  logic [11:0] sx_q, sy_q;
  logic        rb_q, bb_q;
  logic [31:0] now_q;
  logic signed [26:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic [L:0]  idx_q, idx_d;
  logic [13:0] frac_q, frac_d;
  logic [14:0] r_q, r_d, e0_q, e0_d, e1_q, e1_d;
  logic signed [15:0] c_q, c_d;
  logic [7:0]  js_q[2], js_d[2], ang_q[2], ang_d[2];
  logic [11:0] us_q, us_d;
  logic [13:0] duty_q[2], duty_d[2];

  // Output register
  logic        ov_q, ov_d;
  logic [13:0] opd_q, otd_q;
  logic [7:0]  opa_q, ota_q;
  logic        om_q, orl_q, obl_q, load_out;

  jsp_pkg::iter_req_t req;
  jsp_pkg::iter_rsp_t rsp;

  jsp_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  logic               acc_in;
  logic               idle;
  logic [11:0]        samp, cen;
  logic signed [16:0] smooth;
  logic signed [13:0] dif13;
  logic signed [16:0] dscaled;
  logic signed [15:0] xn;
  logic [8:0]         weff;
  logic signed [27:0] sum;
  logic [15:0]        mag;
  logic [14:0]        den;
  logic [31:0]        tnum;
  logic [14:0]        tq;
  logic [L+14:0]      pos;
  logic [L:0]         kk;
  logic [31:0]        kr;
  logic [28:0]        dprod;
  logic [14:0]        y;
  logic signed [16:0] vang;
  logic [23:0]        aprod;
  logic [23:0]        asum;
  logic               md, rl, bl;
  logic [31:0]        elapsed;
  logic signed [15:0] yc, pc;
  logic [10:0]        pv, tv;
  logic [23:0]        pm, tm;
  logic [7:0]         pq, tqr;
  logic [7:0]         angsel;
  logic [27:0]        usmul;
  logic [33:0]        dmul;

  assign idle       = state_q == S_IDLE;
  assign in_stall_o = !idle;
  assign acc_in     = in_valid_i && idle;

  always_comb begin
    samp   = ax_q ? sy_q : sx_q;
    cen    = ax_q ? cy_q : cx_q;
    smooth = ax_q ? smy_q : smx_q;
    dif13  = $signed({1'b0, samp}) - $signed({1'b0, cen});
    dscaled = 17'(dif13) <<< 3;
    if (dscaled > $signed(17'(jsp_pkg::NORM_LIMIT)))       xn = 16'(jsp_pkg::NORM_LIMIT);
    else if (dscaled < -$signed(17'(jsp_pkg::NORM_LIMIT))) xn = -16'(jsp_pkg::NORM_LIMIT);
    else                                                   xn = dscaled[15:0];
    weff = (ew_q > 9'd256) ? 9'd256 : ew_q;
    sum  = 28'(acc_q) + 28'($signed({1'b0, 9'd256 - weff}) * smooth) + 28'sd128;
    mag  = smooth[16] ? 16'(-smooth) : smooth[15:0];
    den  = 15'(jsp_pkg::Q_ONE) - {2'b0, dz_q};
    tnum = ({16'b0, mag - {3'b0, dz_q}} << 14) + {18'b0, den[14:1]};
    tq   = (rsp.res > 32'(jsp_pkg::Q_ONE)) ? 15'(jsp_pkg::Q_ONE) : rsp.res[14:0];
    pos  = (L+15)'(tq) << L;
    kk   = hi_q ? idx_q + (L+1)'(1) : idx_q;
    kr   = 32'(kk) * 32'(r_q);
    dprod = 29'(e1_q - e0_q) * 29'(frac_q);
    y    = e0_q + 15'((dprod + 29'd8192) >> 14);
    vang = ax_q ? 17'(jsp_pkg::Q_ONE) + 17'(c_q) : 17'(jsp_pkg::Q_ONE) - 17'(c_q);
    aprod = 24'(jsp_pkg::ANGLE_SPAN) * 24'(vang[15:0]);
    asum  = aprod + 24'd16384;
    angsel = ang_q[ax_q];
    usmul  = 28'(angsel) * 28'(jsp_pkg::US_RECIP);
    dmul   = 34'(us_q) * 34'(jsp_pkg::DUTY_RECIP);

    md = mode_q;
    rl = red_q;
    bl = blue_q;
    if (rb_q) begin
      rl = 1'b1; bl = 1'b0; md = 1'b0;
    end else if (bb_q) begin
      bl = 1'b1; rl = 1'b0; md = 1'b1;
    end
    elapsed = now_q - last_q;
    if (md && (elapsed > {16'b0, to_q})) begin
      md = 1'b0; rl = 1'b1; bl = 1'b0;
    end

    // remote angles, divide by ten through a reciprocal
    if (yaw_tenths_i > 16'sd900)        yc = 16'sd900;
    else if (yaw_tenths_i < -16'sd900)  yc = -16'sd900;
    else                                yc = yaw_tenths_i;
    if (pitch_tenths_i > 16'sd450)       pc = 16'sd450;
    else if (pitch_tenths_i < -16'sd450) pc = -16'sd450;
    else                                 pc = pitch_tenths_i;
    pv  = 11'(yc + 16'sd905);
    tv  = 11'(16'sd905 - (pc <<< 1));
    pm  = 24'(pv) * 24'd6554;
    tm  = 24'(tv) * 24'd6554;
    pq  = pm[23:16];
    tqr = tm[23:16];
  end

  always_comb begin
    state_d = state_q;
    ax_d    = ax_q;
    sent_d  = sent_q;
    hi_d    = hi_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    idx_d   = idx_q;
    frac_d  = frac_q;
    r_d     = r_q;
    e0_d    = e0_q;
    e1_d    = e1_q;
    c_d     = c_q;
    js_d    = js_q;
    ang_d   = ang_q;
    us_d    = us_q;
    duty_d  = duty_q;
    smx_d   = smx_q;
    smy_d   = smy_q;
    mode_d  = mode_q;
    red_d   = red_q;
    blue_d  = blue_q;
    last_d  = last_q;
    rpan_d  = rpan_q;
    rtilt_d = rtilt_q;
    load_out = 1'b0;
    req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (acc_in) begin
          if (opcode_i == jsp_pkg::OP_TICK) begin
            state_d = S_EMA0;
            ax_d    = 1'b0;
          end else if (opcode_i == jsp_pkg::OP_REMOTE || opcode_i == jsp_pkg::OP_PING) begin
            last_d = now_ms_i;
            if (opcode_i == jsp_pkg::OP_REMOTE && mode_q) begin
              rpan_d  = (pq > 8'(jsp_pkg::REMOTE_MAX)) ? 8'(jsp_pkg::REMOTE_MAX) : pq;
              rtilt_d = (tqr > 8'(jsp_pkg::REMOTE_MAX)) ? 8'(jsp_pkg::REMOTE_MAX) : tqr;
            end
          end
        end
      end
      S_EMA0: begin
        acc_d   = 27'($signed({1'b0, weff}) * xn);
        state_d = S_EMA1;
      end
      S_EMA1: begin
        if (ax_q) smy_d = sum[24:8];
        else      smx_d = sum[24:8];
        state_d = S_SHP;
      end
      S_SHP: begin
        neg_d = smooth[16];
        if (smooth == 17'sd0 || mag < {3'b0, dz_q}) begin
          c_d     = '0;
          state_d = S_ANG;
        end else begin
          state_d = S_TDIV;
        end
      end
      S_TDIV: begin
        req.is_sqrt = 1'b0;
        req.num     = tnum << 2;
        req.den     = {1'b0, den};
        req.steps   = jsp_pkg::T_STEPS;
        if (!sent_q) begin
          req.start = 1'b1;
          sent_d    = 1'b1;
        end else if (rsp.done) begin
          sent_d  = 1'b0;
          idx_d   = pos[L+14:14];
          frac_d  = pos[13:0];
          hi_d    = 1'b0;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        req.is_sqrt = 1'b1;
        req.num     = (32'(kk) << (28 - L)) << 2;
        req.steps   = jsp_pkg::SQ_STEPS;
        if (!sent_q) begin
          req.start = 1'b1;
          sent_d    = 1'b1;
        end else if (rsp.done) begin
          sent_d  = 1'b0;
          r_d     = rsp.res[14:0];
          state_d = S_ENT;
        end
      end
      S_ENT: begin
        if (hi_q) begin
          e1_d    = 15'((kr + 32'(jsp_pkg::CURVE_ENTRIES / 2)) >> L);
          state_d = S_INT;
        end else begin
          e0_d    = 15'((kr + 32'(jsp_pkg::CURVE_ENTRIES / 2)) >> L);
          hi_d    = 1'b1;
          state_d = S_SQ;
        end
      end
      S_INT: begin
        c_d     = neg_q ? -$signed({1'b0, y}) : $signed({1'b0, y});
        state_d = S_ANG;
      end
      S_ANG: begin
        js_d[ax_q] = asum[22:15];
        if (ax_q) begin
          state_d = S_MODE;
        end else begin
          ax_d    = 1'b1;
          state_d = S_EMA0;
        end
      end
      S_MODE: begin
        mode_d   = md;
        red_d    = rl;
        blue_d   = bl;
        ang_d[0] = md ? rpan_q : js_q[0];
        ang_d[1] = md ? rtilt_q : js_q[1];
        ax_d     = 1'b0;
        state_d  = S_US;
      end
      S_US: begin
        us_d    = 12'(jsp_pkg::PULSE_MIN_US) + 12'(usmul >> jsp_pkg::US_SHIFT);
        state_d = S_DUTY;
      end
      S_DUTY: begin
        duty_d[ax_q] = 14'(dmul >> jsp_pkg::DUTY_SHIFT);
        if (ax_q) begin
          state_d = S_OUT;
        end else begin
          ax_d    = 1'b1;
          state_d = S_US;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!ov_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    ov_d = load_out ? 1'b1 : (ov_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= 12'd2048;
      cy_q    <= 12'd2048;
      ew_q    <= 9'd64;
      dz_q    <= 13'd819;
      to_q    <= 16'd3000;
      smx_q   <= '0;
      smy_q   <= '0;
      mode_q  <= 1'b0;
      red_q   <= 1'b0;
      blue_q  <= 1'b0;
      last_q  <= '0;
      rpan_q  <= 8'd90;
      rtilt_q <= 8'd90;
      state_q <= S_IDLE;
      sent_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          jsp_pkg::REG_CENTER_X: cx_q <= cfg_data_i[11:0];
          jsp_pkg::REG_CENTER_Y: cy_q <= cfg_data_i[11:0];
          jsp_pkg::REG_EMA_W:    ew_q <= cfg_data_i[8:0];
          jsp_pkg::REG_DEADZONE: dz_q <= cfg_data_i[12:0];
          jsp_pkg::REG_TIMEOUT:  to_q <= cfg_data_i;
          default: ;
        endcase
      end
      smx_q   <= smx_d;
      smy_q   <= smy_d;
      mode_q  <= mode_d;
      red_q   <= red_d;
      blue_q  <= blue_d;
      last_q  <= last_d;
      rpan_q  <= rpan_d;
      rtilt_q <= rtilt_d;
      state_q <= state_d;
      sent_q  <= sent_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      sx_q  <= sample_x_i;
      sy_q  <= sample_y_i;
      rb_q  <= red_button_i;
      bb_q  <= blue_button_i;
      now_q <= now_ms_i;
    end
    ax_q   <= ax_d;
    hi_q   <= hi_d;
    acc_q  <= acc_d;
    neg_q  <= neg_d;
    idx_q  <= idx_d;
    frac_q <= frac_d;
    r_q    <= r_d;
    e0_q   <= e0_d;
    e1_q   <= e1_d;
    c_q    <= c_d;
    js_q   <= js_d;
    ang_q  <= ang_d;
    us_q   <= us_d;
    duty_q <= duty_d;
    if (load_out) begin
      opd_q <= duty_q[0];
      otd_q <= duty_q[1];
      opa_q <= ang_q[0];
      ota_q <= ang_q[1];
      om_q  <= mode_q;
      orl_q <= red_q;
      obl_q <= blue_q;
    end
  end

  assign out_valid_o   = ov_q;
  assign pan_duty_o    = opd_q;
  assign tilt_duty_o   = otd_q;
  assign pan_angle_o   = opa_q;
  assign tilt_angle_o  = ota_q;
  assign remote_mode_o = om_q;
  assign red_led_o     = orl_q;
  assign blue_led_o    = obl_q;

endmodule
`default_nettype wire

// File: verif/tb_joystick_to_servo_pulse_conditioner_top.sv
// Self-checking bench for the joystick-to-servo pulse conditioner top level.
// Depends on jsp_pkg and the RTL; a bit-exact predictor checks every result beat.
`default_nettype none
module tb_joystick_to_servo_pulse_conditioner_top;

  typedef struct packed {
    logic [13:0] pan_duty;
    logic [13:0] tilt_duty;
    logic [7:0]  pan_ang;
    logic [7:0]  tilt_ang;
    logic        remote_mode;
    logic        red_led;
    logic        blue_led;
  } servo_cmd_t;

  class servo_scoreboard;
    // register copies
    int unsigned ctr_x, ctr_y, ema_w, dz, tmo;
    // filter and mode state
    int          filt_x, filt_y;
    bit          remote_on, lamp_red, lamp_blue;
    int unsigned last_rx_ms, rem_pan, rem_tilt;
    int unsigned curve [0:jsp_pkg::CURVE_ENTRIES];
    servo_cmd_t  pending [$];
    int          errors;

    function new();
      longint unsigned u, r, b;
      for (int k = 0; k <= jsp_pkg::CURVE_ENTRIES; k++) begin
        u = (longint'(k) << 28) / jsp_pkg::CURVE_ENTRIES;
        r = 0;
        b = 64'd1 << 62;
        while (b > u) b >>= 2;
        while (b != 0) begin
          if (u >= r + b) begin
            u -= r + b;
            r = (r >> 1) + b;
          end else begin
            r >>= 1;
          end
          b >>= 2;
        end
        curve[k] = 32'((longint'(k) * r + jsp_pkg::CURVE_ENTRIES / 2)
                       / jsp_pkg::CURVE_ENTRIES);
      end
      ctr_x = 2048; ctr_y = 2048; ema_w = 64; dz = 819; tmo = 3000;
      filt_x = 0; filt_y = 0; remote_on = 0; last_rx_ms = 0;
      rem_pan = 90; rem_tilt = 90; lamp_red = 0; lamp_blue = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        jsp_pkg::REG_CENTER_X: ctr_x = v[11:0];
        jsp_pkg::REG_CENTER_Y: ctr_y = v[11:0];
        jsp_pkg::REG_EMA_W:    ema_w = v[8:0];
        jsp_pkg::REG_DEADZONE: dz = v[12:0];
        jsp_pkg::REG_TIMEOUT:  tmo = v;
        default: ;
      endcase
    endfunction

    function int centered(int unsigned s, int unsigned c);
      int d;
      d = (int'(s) - int'(c)) * 8;
      if (d > int'(jsp_pkg::NORM_LIMIT)) d = jsp_pkg::NORM_LIMIT;
      if (d < -int'(jsp_pkg::NORM_LIMIT)) d = -int'(jsp_pkg::NORM_LIMIT);
      return d;
    endfunction

    function int smooth(int x, int s);
      longint w, sum;
      w = (ema_w > 256) ? 256 : ema_w;
      sum = w * x + (256 - w) * s + 128;
      return int'(sum >>> 8);
    endfunction

    function int shaped(int v);
      int unsigned mag, den, t, pos, idx, frac, y;
      mag = (v < 0) ? -v : v;
      if (mag < dz || v == 0) return 0;
      den = jsp_pkg::Q_ONE - dz;
      t = ((mag - dz) * jsp_pkg::Q_ONE + den / 2) / den;
      if (t > jsp_pkg::Q_ONE) t = jsp_pkg::Q_ONE;
      pos = t * jsp_pkg::CURVE_ENTRIES;
      idx = pos >> 14;
      frac = pos & (jsp_pkg::Q_ONE - 1);
      if (idx >= jsp_pkg::CURVE_ENTRIES) y = curve[jsp_pkg::CURVE_ENTRIES];
      else y = curve[idx] + (((curve[idx + 1] - curve[idx]) * frac + 8192) >> 14);
      return (v < 0) ? -int'(y) : int'(y);
    endfunction

    function logic [13:0] duty(int unsigned a);
      int unsigned us;
      us = jsp_pkg::PULSE_MIN_US + (jsp_pkg::PULSE_SPAN_US * a) / jsp_pkg::ANGLE_FULL;
      return 14'((us << 16) / jsp_pkg::PWM_PERIOD_US);
    endfunction

    function void note_beat(logic [1:0] op, logic [11:0] sx, logic [11:0] sy, bit rb, bit bb,
                            logic [31:0] now, logic signed [15:0] yaw,
                            logic signed [15:0] pitch);
      int p, t, cx, cy;
      int unsigned pj, tj, pan, tilt;
      servo_cmd_t e;
      if (op == jsp_pkg::OP_REMOTE || op == jsp_pkg::OP_PING) begin
        last_rx_ms = now;
        if (op == jsp_pkg::OP_REMOTE && remote_on) begin
          p = yaw; t = pitch;
          if (p > 900) p = 900;
          if (p < -900) p = -900;
          if (t > 450) t = 450;
          if (t < -450) t = -450;
          p = (p + 905) / 10;
          t = (905 - 2 * t) / 10;
          rem_pan = (p > 160) ? 160 : p;
          rem_tilt = (t > 160) ? 160 : t;
        end
        return;
      end
      if (op != jsp_pkg::OP_TICK) return;
      filt_x = smooth(centered(sx, ctr_x), filt_x);
      filt_y = smooth(centered(sy, ctr_y), filt_y);
      cx = shaped(filt_x);
      cy = shaped(filt_y);
      pj = (jsp_pkg::ANGLE_SPAN * int'(jsp_pkg::Q_ONE - cx) + 16384) >> 15;
      tj = (jsp_pkg::ANGLE_SPAN * int'(jsp_pkg::Q_ONE + cy) + 16384) >> 15;
      if (rb) begin
        lamp_red = 1; lamp_blue = 0; remote_on = 0;
      end else if (bb) begin
        lamp_blue = 1; lamp_red = 0; remote_on = 1;
      end
      if (remote_on && (now - last_rx_ms) > tmo) begin
        remote_on = 0; lamp_red = 1; lamp_blue = 0;
      end
      pan = remote_on ? rem_pan : pj;
      tilt = remote_on ? rem_tilt : tj;
      e.pan_duty = duty(pan);
      e.tilt_duty = duty(tilt);
      e.pan_ang = pan[7:0];
      e.tilt_ang = tilt[7:0];
      e.remote_mode = remote_on;
      e.red_led = lamp_red;
      e.blue_led = lamp_blue;
      pending.push_back(e);
    endfunction

    function void check_result(servo_cmd_t got);
      servo_cmd_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat pan=%0d tilt=%0d",
                                   got.pan_ang, got.tilt_ang);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp %0d/%0d %0d/%0d m%0b r%0b b%0b got %0d/%0d %0d/%0d m%0b r%0b b%0b",
                   e.pan_duty, e.tilt_duty, e.pan_ang, e.tilt_ang, e.remote_mode,
                   e.red_led, e.blue_led, got.pan_duty, got.tilt_duty, got.pan_ang,
                   got.tilt_ang, got.remote_mode, got.red_led, got.blue_led);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_idx = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [1:0] opcode = '0;
  logic [11:0] sample_x = '0, sample_y = '0;
  logic btn_red = 0, btn_blue = 0;
  logic [31:0] now_ms = '0;
  logic signed [15:0] yaw = '0, pitch = '0;
  logic [13:0] pan_duty, tilt_duty;
  logic [7:0] pan_deg, tilt_deg;
  logic remote_mode, red_led, blue_led;

  servo_scoreboard sb = new();
  int unsigned cycles = 0;
  bit rx_idle_free = 0;
  logic [31:0] clock_ms = 0;

  always #6 clk = ~clk;

  joystick_to_servo_pulse_conditioner_top u_top (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .sample_x_i(sample_x), .sample_y_i(sample_y),
    .red_button_i(btn_red), .blue_button_i(btn_blue), .now_ms_i(now_ms),
    .yaw_tenths_i(yaw), .pitch_tenths_i(pitch), .out_valid_o(out_valid),
    .out_stall_i(out_stall), .pan_duty_o(pan_duty), .tilt_duty_o(tilt_duty),
    .pan_angle_o(pan_deg), .tilt_angle_o(tilt_deg), .remote_mode_o(remote_mode),
    .red_led_o(red_led), .blue_led_o(blue_led));

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: check each accepted beat and draw a new stall length.
  int rx_wait = 0;
  always @(posedge clk) begin
    servo_cmd_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.pan_duty = pan_duty; got.tilt_duty = tilt_duty;
        got.pan_ang = pan_deg; got.tilt_ang = tilt_deg;
        got.remote_mode = remote_mode; got.red_led = red_led; got.blue_led = blue_led;
        sb.check_result(got);
        rx_wait = rx_idle_free ? 0 : $urandom_range(0, 12);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= v;
    sb.write_reg(idx, v);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Present one beat; hold it until accepted.
  task automatic send_beat(logic [1:0] op, logic [11:0] sx, logic [11:0] sy, bit rb, bit bb,
                           logic [31:0] now, logic signed [15:0] yw,
                           logic signed [15:0] pt, int gap);
    repeat (gap) begin
      @(posedge clk);
      in_valid <= 0;
    end
    @(posedge clk);
    in_valid <= 1; opcode <= op; sample_x <= sx; sample_y <= sy;
    btn_red <= rb; btn_blue <= bb; now_ms <= now; yaw <= yw; pitch <= pt;
    do @(posedge clk); while (in_stall);
    sb.note_beat(op, sx, sy, rb, bb, now, yw, pt);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic rand_beat(int gap);
    int sel;
    logic [1:0] op;
    sel = $urandom_range(0, 99);
    op = (sel < 60) ? jsp_pkg::OP_TICK : (sel < 82) ? jsp_pkg::OP_REMOTE :
         (sel < 97) ? jsp_pkg::OP_PING : jsp_pkg::OP_RSVD;
    // time mostly advances by small steps, sometimes jumps
    clock_ms += ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 1500);
    send_beat(op, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
              $urandom_range(0, 9) == 0, $urandom_range(0, 5) == 0, clock_ms,
              ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2000) - 1000),
              ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1000) - 500),
              gap);
  endtask

  initial begin
    int gap;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    // directed: extremes, both buttons, remote clamps, timeout, ignored opcode
    send_beat(jsp_pkg::OP_TICK, 12'd0, 12'd4095, 0, 0, 32'd10, 0, 0, 0);
    send_beat(jsp_pkg::OP_TICK, 12'd4095, 12'd0, 0, 0, 32'd20, 0, 0, 0);
    send_beat(jsp_pkg::OP_TICK, 12'd2048, 12'd2048, 1, 1, 32'd30, 0, 0, 0);
    send_beat(jsp_pkg::OP_TICK, 12'd2100, 12'd1990, 0, 1, 32'd40, 0, 0, 0);
    send_beat(jsp_pkg::OP_REMOTE, 0, 0, 0, 0, 32'd50, 16'sh7FFF, -16'sh8000, 0);
    send_beat(jsp_pkg::OP_TICK, 0, 0, 0, 0, 32'd60, 0, 0, 0);
    send_beat(jsp_pkg::OP_REMOTE, 0, 0, 0, 0, 32'd70, -16'sh8000, 16'sh7FFF, 0);
    send_beat(jsp_pkg::OP_TICK, 0, 0, 0, 0, 32'd80, 0, 0, 0);
    send_beat(jsp_pkg::OP_REMOTE, 0, 0, 0, 0, 32'd90, 16'sd5, -16'sd3, 0);
    send_beat(jsp_pkg::OP_RSVD, 12'hFFF, 12'hFFF, 1, 1, 32'hFFFF_FFFF, -1, -1, 0);
    send_beat(jsp_pkg::OP_PING, 0, 0, 0, 0, 32'hFFFF_F000, 0, 0, 0);
    send_beat(jsp_pkg::OP_TICK, 12'd4095, 12'd4095, 0, 0, 32'd100, 0, 0, 0);
    send_beat(jsp_pkg::OP_TICK, 12'd4095, 12'd4095, 0, 0, 32'd5000, 0, 0, 0);
    drain();
    write_reg(jsp_pkg::REG_EMA_W, 16'd256);
    write_reg(jsp_pkg::REG_DEADZONE, 16'd0);
    write_reg(jsp_pkg::REG_CENTER_X, 16'd0);
    write_reg(jsp_pkg::REG_CENTER_Y, 16'd4095);
    write_reg(jsp_pkg::REG_TIMEOUT, 16'd0);
    send_beat(jsp_pkg::OP_TICK, 12'd4095, 12'd0, 0, 0, 32'd1, 0, 0, 0);
    send_beat(jsp_pkg::OP_TICK, 12'd1, 12'd4094, 0, 1, 32'd1, 0, 0, 0);
    send_beat(jsp_pkg::OP_TICK, 12'd0, 12'd4095, 0, 0, 32'd1, 0, 0, 0);
    drain();
    write_reg(jsp_pkg::REG_EMA_W, 16'h1FF);
    write_reg(jsp_pkg::REG_DEADZONE, 16'h1FFF);
    write_reg(jsp_pkg::REG_TIMEOUT, 16'hFFFF);
    send_beat(jsp_pkg::OP_TICK, 12'd4095, 12'd0, 0, 0, 32'd2, 0, 0, 0);
    send_beat(jsp_pkg::OP_TICK, 12'd2048, 12'd2048, 0, 0, 32'd3, 0, 0, 0);
    drain();
    // random phases across register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(jsp_pkg::REG_CENTER_X, (ph == 0) ? 16'd2048 : 16'($urandom_range(0, 4095)));
      write_reg(jsp_pkg::REG_CENTER_Y, (ph == 0) ? 16'd2048 : 16'($urandom_range(0, 4095)));
      write_reg(jsp_pkg::REG_EMA_W, (ph == 1) ? 16'd0 : 16'($urandom_range(0, 511)));
      write_reg(jsp_pkg::REG_DEADZONE, (ph == 2) ? 16'd8191 : 16'($urandom_range(0, 3000)));
      write_reg(jsp_pkg::REG_TIMEOUT, (ph == 3) ? 16'd65535 : 16'($urandom_range(0, 4000)));
      rx_idle_free = (ph == 4);
      for (int i = 0; i < 305; i++) begin
        gap = (ph == 4 || (i % 50) < 8) ? 0 : $urandom_range(0, 12);
        rand_beat(gap);
      end
      drain();
    end
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
